[rtl/lpcc_pkg.sv]
`timescale 1ns / 1ps

package lpcc_pkg;

    // fixed field widths
    localparam int LEN_W  = 5;
    localparam int LIMB_W = 5;
    localparam int PT_W   = 8;
    localparam int VAL_W  = 24;
    localparam int PT_DW  = 2 * VAL_W;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W  = 64;

    // defaults for the top level parameters
    localparam int MAX_LIMBS_DEF = 16;
    localparam int POINTS_DEF    = 256;
    localparam int DEPTH_DEF     = MAX_LIMBS_DEF * POINTS_DEF;
    localparam int ADDR_W_DEF    = (DEPTH_DEF > 1) ? $clog2(DEPTH_DEF) : 1;

    // commands
    localparam logic [1:0] CMD_WR_A    = 2'd0;
    localparam logic [1:0] CMD_WR_B    = 2'd1;
    localparam logic [1:0] CMD_RD_TERM = 2'd2;

    // register indexes
    localparam logic [1:0] REG_A_LENGTH      = 2'd0;
    localparam logic [1:0] REG_B_LENGTH      = 2'd1;
    localparam logic [1:0] REG_RESULT_LENGTH = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ISSUE,
        S_DRAIN,
        S_FINISH
    } lpcc_state_t;

    typedef struct packed {
        logic clear;
        logic in_valid;
    } lpcc_mac_ctrl_t;

endpackage

[rtl/lpcc_mem.sv]
`timescale 1ns / 1ps

module lpcc_mem #(
    parameter int DEPTH  = lpcc_pkg::DEPTH_DEF,
    parameter int ADDR_W = lpcc_pkg::ADDR_W_DEF
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [lpcc_pkg::PT_DW-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [lpcc_pkg::PT_DW-1:0]   rd_data
);

    logic [lpcc_pkg::PT_DW-1:0] mem_reg [DEPTH];
    logic [lpcc_pkg::PT_DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lpcc_cmac.sv]
`timescale 1ns / 1ps

module lpcc_cmac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpcc_pkg::lpcc_mac_ctrl_t            ctrl,
    input  logic [lpcc_pkg::PT_DW-1:0]          a_data,
    input  logic [lpcc_pkg::PT_DW-1:0]          b_data,
    output logic signed [lpcc_pkg::SUM_W-1:0]   acc_re,
    output logic signed [lpcc_pkg::SUM_W-1:0]   acc_im,
    output logic                                busy
);

    localparam int VW = lpcc_pkg::VAL_W;
    localparam int PW = lpcc_pkg::PROD_W;
    localparam int SW = lpcc_pkg::SUM_W;

    logic signed [VW-1:0] ar, ai, br, bi;

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0] p_rr_next, p_ii_next, p_ri_next, p_ir_next;
    logic signed [PW:0]   t_re_reg, t_im_reg, t_re_next, t_im_next;
    logic signed [SW-1:0] acc_re_reg, acc_im_reg, acc_re_next, acc_im_next;
    logic                 vld1_reg, vld2_reg;

    assign ar = a_data[VW-1:0];
    assign ai = a_data[2*VW-1:VW];
    assign br = b_data[VW-1:0];
    assign bi = b_data[2*VW-1:VW];

    // stage 1: four partial products
    always_comb
    begin
        p_rr_next = PW'(ar * br);
        p_ii_next = PW'(ai * bi);
        p_ri_next = PW'(ar * bi);
        p_ir_next = PW'(ai * br);
    end

    // stage 2: complex combine
    always_comb
    begin
        t_re_next = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg);
        t_im_next = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg);
    end

    // stage 3: accumulate
    always_comb
    begin
        if (ctrl.clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (vld2_reg)
        begin
            acc_re_next = acc_re_reg + SW'(t_re_reg);
            acc_im_next = acc_im_reg + SW'(t_im_reg);
        end
        else
        begin
            acc_re_next = acc_re_reg;
            acc_im_next = acc_im_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= ctrl.in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg   <= p_rr_next;
        p_ii_reg   <= p_ii_next;
        p_ri_reg   <= p_ri_next;
        p_ir_reg   <= p_ir_next;
        t_re_reg   <= t_re_next;
        t_im_reg   <= t_im_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;
    assign busy   = vld1_reg | vld2_reg;

endmodule

[rtl/limb_pointwise_complex_convolution_top.sv]
// a new item is accepted only after the previous result has been loaded into the output register
// n <= min(a_length, b_length); one product a cycle through the shared multiply-accumulate, then a drain
// the output register lets the next item be accepted while a result waits on m_tready
// reset: rst_n async active low, clears control and sets all length registers to 1
// point stores are undefined until written and get no clearing pass
`timescale 1ns / 1ps

module limb_pointwise_complex_convolution_top #(
    parameter int MAX_LIMBS = lpcc_pkg::MAX_LIMBS_DEF,
    parameter int POINTS    = lpcc_pkg::POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // limb[4:0], point[12:5], value_re[36:13], value_im[60:37]
    input  logic [1:0]   s_tuser,   // cmd[1:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // sum_re[63:0], sum_im[127:64]
    output logic [0:0]   m_tuser,   // term_valid[0]
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DEPTH  = MAX_LIMBS * POINTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW     = lpcc_pkg::LEN_W;
    localparam int KW     = lpcc_pkg::LIMB_W;
    localparam int PW     = lpcc_pkg::PT_W;
    localparam int VW     = lpcc_pkg::VAL_W;
    localparam int DW     = lpcc_pkg::PT_DW;
    localparam int SW     = lpcc_pkg::SUM_W;

    // ---------------------------------------------------------------
    // input item fields
    // ---------------------------------------------------------------
    logic [1:0]    in_cmd;
    logic [KW-1:0] in_limb;
    logic [PW-1:0] in_point;
    logic [VW-1:0] in_re, in_im;

    assign in_cmd   = s_tuser[1:0];
    assign in_limb  = s_tdata[KW-1:0];
    assign in_point = s_tdata[KW+PW-1:KW];
    assign in_re    = s_tdata[KW+PW+VW-1:KW+PW];
    assign in_im    = s_tdata[KW+PW+2*VW-1:KW+PW+VW];

    // ---------------------------------------------------------------
    // configuration registers: write only while the block is idle (the block does not enforce this)
    // ---------------------------------------------------------------
    logic [LW-1:0] a_length_reg, b_length_reg, result_length_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_length_reg      <= lpcc_pkg::LEN_RESET;
            b_length_reg      <= lpcc_pkg::LEN_RESET;
            result_length_reg <= lpcc_pkg::LEN_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                lpcc_pkg::REG_A_LENGTH:      a_length_reg      <= pwdata[LW-1:0];
                lpcc_pkg::REG_B_LENGTH:      b_length_reg      <= pwdata[LW-1:0];
                lpcc_pkg::REG_RESULT_LENGTH: result_length_reg <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lpcc_pkg::REG_A_LENGTH:      prdata = 32'(a_length_reg);
            lpcc_pkg::REG_B_LENGTH:      prdata = 32'(b_length_reg);
            lpcc_pkg::REG_RESULT_LENGTH: prdata = 32'(result_length_reg);
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // effective lengths: saturate at the limb count of the stores
    // ---------------------------------------------------------------
    logic [LW-1:0] la, lb;
    logic [LW:0]   conv_len;

    assign la = (32'(a_length_reg) > MAX_LIMBS) ? LW'(MAX_LIMBS) : a_length_reg;
    assign lb = (32'(b_length_reg) > MAX_LIMBS) ? LW'(MAX_LIMBS) : b_length_reg;
    // an empty operand gives an empty convolution
    assign conv_len = (la == '0 || lb == '0) ? '0
                    : ((LW+1)'(la) + (LW+1)'(lb) - (LW+1)'(1));

    // ---------------------------------------------------------------
    // state and datapath registers
    // ---------------------------------------------------------------
    lpcc_pkg::lpcc_state_t state_reg, state_next;

    logic [KW-1:0]     k_reg;
    logic [PW-1:0]     point_reg;
    logic [LW-1:0]     cnt_reg, cnt_next;
    logic [ADDR_W-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic              tv_reg;
    logic              rd_vld_reg;
    logic              out_valid_reg, out_valid_next;
    logic [SW-1:0]     out_re_reg, out_im_reg;
    logic              out_tv_reg;

    // control outputs of the sequencer
    logic                     accept;
    logic                     rd_en;
    logic                     load_out;
    lpcc_pkg::lpcc_mac_ctrl_t mac_ctrl;

    // accept-time decode
    logic              wr_ok, rd_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_a, wr_b;

    assign wr_ok   = (32'(in_limb) < MAX_LIMBS) && (32'(in_point) < POINTS);
    assign rd_ok   = ((LW+1)'(in_limb) < conv_len) && (in_limb < result_length_reg)
                     && (32'(in_point) < POINTS);
    assign wr_addr = ADDR_W'(32'(in_limb) * POINTS + 32'(in_point));
    assign wr_a    = accept && wr_ok && (in_cmd == lpcc_pkg::CMD_WR_A);
    assign wr_b    = accept && wr_ok && (in_cmd == lpcc_pkg::CMD_WR_B);

    // setup: limb range of the term, i from lo to hi, b limb k - i
    logic [LW-1:0]     lo, hi, n_prod;
    logic [ADDR_W-1:0] ia_start, ib_start;

    always_comb
    begin
        if ((LW+1)'(k_reg) + (LW+1)'(1) > (LW+1)'(lb))
        begin
            lo = LW'(k_reg) + LW'(1) - lb;
        end
        else
        begin
            lo = '0;
        end
        if (LW'(k_reg) < la - LW'(1))
        begin
            hi = LW'(k_reg);
        end
        else
        begin
            hi = la - LW'(1);
        end
        n_prod   = hi - lo + LW'(1);
        ia_start = ADDR_W'(32'(lo) * POINTS + 32'(point_reg));
        ib_start = ADDR_W'(32'(LW'(k_reg) - lo) * POINTS + 32'(point_reg));
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    logic mac_busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpcc_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_cmd == lpcc_pkg::CMD_RD_TERM && rd_ok)
                    begin
                        state_next = lpcc_pkg::S_SETUP;
                    end
                    else
                    begin
                        state_next = lpcc_pkg::S_FINISH;
                    end
                end
            end
            lpcc_pkg::S_SETUP:
            begin
                state_next = lpcc_pkg::S_ISSUE;
            end
            lpcc_pkg::S_ISSUE:
            begin
                if (cnt_reg == LW'(1))
                begin
                    state_next = lpcc_pkg::S_DRAIN;
                end
            end
            lpcc_pkg::S_DRAIN:
            begin
                // wait until the last product has reached the accumulator
                if (!rd_vld_reg && !mac_busy)
                begin
                    state_next = lpcc_pkg::S_FINISH;
                end
            end
            lpcc_pkg::S_FINISH:
            begin
                if (load_out)
                begin
                    state_next = lpcc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpcc_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        s_tready          = 1'b0;
        rd_en             = 1'b0;
        load_out          = 1'b0;
        case (state_reg)
            lpcc_pkg::S_IDLE:   s_tready = 1'b1;
            lpcc_pkg::S_ISSUE:  rd_en    = 1'b1;
            lpcc_pkg::S_FINISH: load_out = !out_valid_reg || m_tready;
            default: ;
        endcase
        accept            = s_tready && s_tvalid;
        // every item starts from a zero sum, so non-reads return zero
        mac_ctrl.clear    = accept;
        mac_ctrl.in_valid = rd_vld_reg;
    end

    // ---------------------------------------------------------------
    // address walk and output register
    // ---------------------------------------------------------------
    always_comb
    begin
        cnt_next = cnt_reg;
        ia_next  = ia_reg;
        ib_next  = ib_reg;
        if (state_reg == lpcc_pkg::S_SETUP)
        begin
            cnt_next = n_prod;
            ia_next  = ia_start;
            ib_next  = ib_start;
        end
        else if (rd_en)
        begin
            // a limb steps by one row of points
            cnt_next = cnt_reg - LW'(1);
            ia_next  = ia_reg + ADDR_W'(POINTS);
            ib_next  = ib_reg - ADDR_W'(POINTS);
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpcc_pkg::S_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    logic signed [SW-1:0] acc_re, acc_im;

    always_ff @(posedge clk)
    begin
        ia_reg <= ia_next;
        ib_reg <= ib_next;
        if (accept)
        begin
            k_reg     <= in_limb;
            point_reg <= in_point;
            tv_reg    <= (in_cmd == lpcc_pkg::CMD_RD_TERM) && rd_ok;
        end
        if (load_out)
        begin
            out_re_reg <= acc_re;
            out_im_reg <= acc_im;
            out_tv_reg <= tv_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_im_reg, out_re_reg};
    assign m_tuser  = out_tv_reg;

    // ---------------------------------------------------------------
    // point stores, {im, re} per entry
    // ---------------------------------------------------------------
    logic [DW-1:0] wr_data, a_rd_data, b_rd_data;

    assign wr_data = {in_im, in_re};

    lpcc_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ia_reg),
        .rd_data (a_rd_data)
    );

    lpcc_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ib_reg),
        .rd_data (b_rd_data)
    );

    // shared complex multiply-accumulate, one product per cycle
    lpcc_cmac u_cmac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_rd_data),
        .b_data (b_rd_data),
        .acc_re (acc_re),
        .acc_im (acc_im),
        .busy   (mac_busy)
    );

`ifndef SYNTH
    // a result without term_valid, a write or a read outside the convolution, is all zero
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("invalid term with nonzero sum");

    // the multiply pipeline is empty whenever a new item can be taken
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpcc_pkg::S_IDLE) |-> (!rd_vld_reg && !mac_busy))
        else $error("multiply pipeline busy while idle");

    // the product count never runs out while reads are issued
    a_issue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpcc_pkg::S_ISSUE) |-> (cnt_reg != '0))
        else $error("read issued with zero product count");
`endif

endmodule
